[sv/rgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgr_pkg
// Shared types and codes of the rocker gesture recogniser.
// ----------------------------------------------------------------------------
package rgr_pkg;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_MOVE_THRESHOLD = '0;
    localparam logic [7:0] MOVE_THRESHOLD_RST = 8'd10;

    // Event kinds
    localparam logic [3:0] K_LDOWN = 4'd0;
    localparam logic [3:0] K_RDOWN = 4'd1;
    localparam logic [3:0] K_LDBL  = 4'd2;
    localparam logic [3:0] K_RDBL  = 4'd3;
    localparam logic [3:0] K_LUP   = 4'd4;
    localparam logic [3:0] K_RUP   = 4'd5;
    localparam logic [3:0] K_MOVE  = 4'd6;

    // Verdicts
    localparam logic [2:0] V_NONE    = 3'd0;
    localparam logic [2:0] V_INIT    = 3'd1;
    localparam logic [2:0] V_SWALLOW = 3'd2;
    localparam logic [2:0] V_TRIG    = 3'd3;
    localparam logic [2:0] V_DISCARD = 3'd4;
    localparam logic [2:0] V_CANCEL  = 3'd5;
    localparam logic [2:0] V_END     = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_INIT = 3'b010,
        PH_TRIG = 3'b100
    } t_phase;

    typedef struct packed {
        logic [3:0]         kind;
        logic               left_held;
        logic               right_held;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in;

    typedef struct packed {
        logic [2:0] verdict;
        logic       started_left;
    } t_out;

    typedef struct packed {
        t_phase             phase;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic               left_origin;
    } t_state;

endpackage

[sv/rgr_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgr_apb_regs
// APB register file: holds the movement threshold.
// ----------------------------------------------------------------------------
module rgr_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rgr_pkg::ADDR_W-1:0] paddr,
    input  logic [rgr_pkg::DATA_W-1:0] pwdata,
    output logic [rgr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [7:0]                 o_move_threshold
);
    import rgr_pkg::*;

    logic [7:0] r_move_threshold;
    logic       wr_en;
    logic       sel_thr;

    assign pready  = 1'b1;
    assign sel_thr = (paddr[ADDR_W-1:2] == REG_MOVE_THRESHOLD);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_threshold <= MOVE_THRESHOLD_RST;
        end else if (wr_en && sel_thr) begin
            r_move_threshold <= pwdata[7:0];
        end
    end

    // paddr[1:0] is the byte lane, ignored
    always_comb begin
        prdata = '0;
        if (sel_thr) begin
            prdata = {{(DATA_W-8){1'b0}}, r_move_threshold};
        end
    end

    assign o_move_threshold = r_move_threshold;

endmodule

[sv/rgr_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgr_step
// Next-state and verdict logic for one pointer event.
// ----------------------------------------------------------------------------
module rgr_step (
    input  rgr_pkg::t_in    i_event,
    input  rgr_pkg::t_state i_state,
    input  logic [7:0]      i_move_threshold,
    output rgr_pkg::t_state o_state,
    output logic [2:0]      o_verdict
);
    import rgr_pkg::*;

    logic              held;
    logic [3:0]        opp_down;
    logic [3:0]        opp_up;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]       adx;
    logic [16:0]       ady;
    logic              too_far;
    logic              any_down;

    assign held     = i_state.left_origin ? i_event.left_held : i_event.right_held;
    assign opp_down = i_state.left_origin ? K_RDOWN : K_LDOWN;
    assign opp_up   = i_state.left_origin ? K_RUP : K_LUP;

    // exact 17-bit distances, no wrap
    assign dx  = 17'(i_event.pos_x) - 17'(i_state.start_x);
    assign dy  = 17'(i_event.pos_y) - 17'(i_state.start_y);
    assign adx = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady = dy[16] ? 17'(-dy) : 17'(dy);
    assign too_far = (adx > {9'd0, i_move_threshold}) ||
                     (ady > {9'd0, i_move_threshold});

    always_comb begin
        case (i_event.kind) inside
            K_LDOWN, K_RDOWN, K_LDBL, K_RDBL: any_down = 1'b1;
            default:                          any_down = 1'b0;
        endcase
    end

    always_comb begin
        o_state   = i_state;
        o_verdict = V_NONE;
        unique case (i_state.phase)
            PH_INIT: begin
                if (i_event.kind == K_MOVE && held) begin
                    if (too_far) begin
                        o_state.phase = PH_IDLE;
                        o_verdict     = V_CANCEL;
                    end else begin
                        o_verdict = V_SWALLOW;
                    end
                end else if (i_event.kind == opp_down && held) begin
                    o_state.phase = PH_TRIG;
                    o_verdict     = V_TRIG;
                end else if (any_down) begin
                    o_verdict = V_DISCARD;
                end else begin
                    o_state.phase = PH_IDLE;
                    o_verdict     = V_CANCEL;
                end
            end
            PH_TRIG: begin
                if (!held || (i_event.kind != opp_down && i_event.kind != opp_up &&
                              i_event.kind != K_MOVE)) begin
                    o_state.phase = PH_IDLE;
                    o_verdict     = V_END;
                end else begin
                    o_verdict = V_SWALLOW;
                end
            end
            default: begin
                // idle, and any broken phase code
                o_state.phase = PH_IDLE;
                if (i_event.kind == K_LDOWN || i_event.kind == K_RDOWN) begin
                    o_state.start_x     = i_event.pos_x;
                    o_state.start_y     = i_event.pos_y;
                    o_state.left_origin = (i_event.kind == K_LDOWN);
                    o_state.phase       = PH_INIT;
                    o_verdict           = V_INIT;
                end
            end
        endcase
    end

endmodule

[sv/rocker_gesture_recognizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocker_gesture_recognizer
// Follows a mouse rocker gesture over a stream of pointer events and gives
// one verdict per event.
// ----------------------------------------------------------------------------
// Result: registered; valid in the cycle after the request is accepted.
// Throughput: one request per cycle, limited only by the result register;
//   a new request is taken while the held result is being taken.
// Reset (synchronous, active low): phase idle, start point -1/-1, left origin
//   clear, threshold 10, result register empty.
// ----------------------------------------------------------------------------
module rocker_gesture_recognizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // event request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  rgr_pkg::t_in               i_in_data,
    // verdict channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output rgr_pkg::t_out              o_out_data,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rgr_pkg::ADDR_W-1:0] paddr,
    input  logic [rgr_pkg::DATA_W-1:0] pwdata,
    output logic [rgr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rgr_pkg::*;

    logic [7:0] move_threshold;
    t_state     r_state;
    t_state     n_state;
    logic [2:0] n_verdict;
    logic       r_out_valid;
    t_out       r_out_data;
    logic       accept;

    rgr_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_move_threshold (move_threshold)
    );

    // Pure function of the request, the gesture state and the movement threshold
    rgr_step u_step (
        .i_event          (i_in_data),
        .i_state          (r_state),
        .i_move_threshold (move_threshold),
        .o_state          (n_state),
        .o_verdict        (n_verdict)
    );

    // Result register frees up in the same cycle it is drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Gesture state: updated once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.start_x     <= '1;
            r_state.start_y     <= '1;
            r_state.left_origin <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; started_left reflects the state after the step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.verdict      <= n_verdict;
            r_out_data.started_left <= n_state.left_origin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
